// ----- hw/rtl/gdad_pkg.sv -----
// ----------------------------------------------------------------------------
// gdad_pkg: shared constants and tables for the Gregorian date adder
// Calendar cycle lengths, reciprocal constants and the month start table.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_IN_W   = 14;
  localparam int YEAR_OUT_W  = 22;
  localparam int BASE_W      = 24;   // ordinal of the start date before the offset

  localparam int DAYS_400    = 146097;
  localparam int DAYS_100    = 36524;
  localparam int DAYS_4      = 1461;
  localparam int DAYS_1      = 365;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x below 2**14
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_Q_W   = 8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Day of year (from 0) on which month index k (0 = January) starts.
  function automatic logic [8:0] month_start(input logic [3:0] k, input logic leap);
    logic [8:0] s;
    case (k)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd334;
    endcase
    if (leap && k > 4'd1) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/gdad_front.sv -----
// ----------------------------------------------------------------------------
// gdad_front: date to day ordinal
// Two-stage pipeline that turns the start date into an ordinal and adds days.
// ----------------------------------------------------------------------------
module gdad_front import gdad_pkg::*; #(
  parameter int OFFSET_BITS = 30,
  localparam int ORD_W = ((OFFSET_BITS > BASE_W) ? OFFSET_BITS : BASE_W) + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DAY_W-1:0]       start_day,
  input  logic [MONTH_W-1:0]     start_month,
  input  logic [YEAR_IN_W-1:0]   start_year,
  input  logic [OFFSET_BITS-1:0] days_to_add,
  output logic                   push,
  output logic [ORD_W-1:0]       push_ord,
  input  logic                   q_full
);

  localparam int PROD_W = YEAR_IN_W + 13;

  logic en;
  logic a_valid, b_valid;

  logic [22:0]             a_y365;
  logic [YEAR_IN_W-1:0]    a_y1, a_yr;
  logic [DIV100_Q_W-1:0]   a_qy1, a_qyr;
  logic [8:0]              a_db;
  logic                    a_late;
  logic [DAY_W-1:0]        a_day;
  logic [OFFSET_BITS-1:0]  a_add;
  logic [ORD_W-1:0]        b_ord;

  logic [YEAR_IN_W-1:0]    y1;
  logic [PROD_W-1:0]       prod_y1, prod_yr;
  logic [MONTH_W-1:0]      m;
  logic                    cent, leap;
  logic [BASE_W-1:0]       base;
  logic [ORD_W-1:0]        ord;

  // hold both stages while the queue cannot take the item in the last stage
  assign en       = !(b_valid && q_full);
  assign in_ready = en && !rst;
  assign push     = b_valid && !q_full;
  assign push_ord = b_ord;

  always_comb begin
    y1      = (start_year != '0) ? start_year - 14'd1 : '0;
    prod_y1 = PROD_W'(y1) * PROD_W'(DIV100_MUL);
    prod_yr = PROD_W'(start_year) * PROD_W'(DIV100_MUL);
    case (start_month) inside
      4'd0:                m = MONTH_JAN;
      [MONTH_JAN:MONTH_DEC]: m = start_month;
      default:             m = MONTH_DEC;
    endcase
  end

  always_comb begin
    cent = (a_yr == YEAR_IN_W'(16'(a_qyr) * 16'd100));
    leap = ((a_yr[1:0] == 2'd0) && !cent) || (cent && (a_qyr[1:0] == 2'd0));
    base = BASE_W'(a_y365) + BASE_W'(a_y1 >> 2) + BASE_W'(a_qy1 >> 2)
         + BASE_W'(a_db) + BASE_W'(a_late && leap) + BASE_W'(a_day)
         - BASE_W'(a_qy1);
    // day zero of January of year one clamps at the first ordinal
    ord  = ((base == '0) ? '0 : ORD_W'(base - BASE_W'(1))) + ORD_W'(a_add);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_y365 <= 23'(y1) * 23'(DAYS_1);
      a_y1   <= y1;
      a_yr   <= start_year;
      a_qy1  <= prod_y1[DIV100_SHIFT +: DIV100_Q_W];
      a_qyr  <= prod_yr[DIV100_SHIFT +: DIV100_Q_W];
      a_db   <= month_start(m - 4'd1, 1'b0);
      a_late <= (m > MONTH_FEB);
      a_day  <= start_day;
      a_add  <= days_to_add;
      b_ord  <= ord;
    end
  end

endmodule

// ----- hw/rtl/gdad_queue.sv -----
// ----------------------------------------------------------------------------
// gdad_queue: small ordinal queue
// Decouples the front pipeline from the back pipeline.
// ----------------------------------------------------------------------------
module gdad_queue import gdad_pkg::*; #(
  parameter int WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push, do_pop;

  assign full     = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_PTR_W + 1)'(do_push) - (QUEUE_PTR_W + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/gdad_back.sv -----
// ----------------------------------------------------------------------------
// gdad_back: day ordinal to date
// Reciprocal division by the 400-year cycle, then the century, 4-year, year
// and month steps, ending in the output register.
// ----------------------------------------------------------------------------
module gdad_back import gdad_pkg::*; #(
  parameter int OFFSET_BITS = 30,
  localparam int ORD_W = ((OFFSET_BITS > BASE_W) ? OFFSET_BITS : BASE_W) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  logic [ORD_W-1:0]      q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DAY_W-1:0]      result_day,
  output logic [MONTH_W-1:0]    result_month,
  output logic [YEAR_OUT_W-1:0] result_year
);

  localparam int QW = ORD_W - 17;   // 146097 exceeds 2**17
  localparam int YW = QW + 10;
  localparam int PW = 2 * QW;
  localparam int RW = 19;           // estimate remainder stays below 3 * 146097
  // floor(2**ORD_W / 146097), the 400-year reciprocal scaled by 2**ORD_W
  localparam logic [QW-1:0] RECIP_400 = QW'((64'd1 << ORD_W) / 64'(DAYS_400));

  logic en;

  logic             r_valid, p_valid, s_valid, t_valid;
  logic [ORD_W-1:0] r_ord;
  logic [QW-1:0]    p_qest, s_qest, t_quo;
  logic [RW-1:0]    p_lo, s_rem;
  logic [17:0]      t_rem;

  logic          c_valid, d_valid, e_valid;
  logic [QW-1:0] c_quo;
  logic [2:0]    c_c100, d_c100;
  logic [15:0]   c_rem;
  logic [YW-1:0] d_base, e_ry;
  logic [4:0]    d_c4;
  logic [10:0]   d_rem;
  logic [8:0]    e_rem;
  logic          e_leap, e_last;

  logic [PW-1:0] est_prod;
  logic [RW-1:0] est_back;
  logic [QW-1:0] fix_quo;
  logic [17:0]   fix_rem;
  logic [17:0]   r18, sub100;
  logic [2:0]    c100;
  logic [15:0]   r4y;
  logic [4:0]    c4;
  logic [2:0]    c1;
  logic [8:0]    sub1;
  logic [3:0]    mon;
  logic [8:0]    mstart;

  // advance the whole back pipeline unless the output register is stalled
  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      t_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      r_valid   <= pop;
      p_valid   <= r_valid;
      s_valid   <= p_valid;
      t_valid   <= s_valid;
      c_valid   <= t_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  // quotient estimate from the top bits, short by at most two 400-year cycles;
  // the remainder only needs its low bits since it stays below 2**RW
  always_comb begin
    est_prod = PW'(r_ord[ORD_W-1:17]) * PW'(RECIP_400);
    est_back = RW'(p_qest) * RW'(DAYS_400);
  end

  // add back the missing 400-year cycles
  always_comb begin
    if (s_rem >= RW'(2 * DAYS_400)) begin
      fix_quo = s_qest + QW'(2);
      fix_rem = 18'(s_rem - RW'(2 * DAYS_400));
    end else if (s_rem >= RW'(DAYS_400)) begin
      fix_quo = s_qest + QW'(1);
      fix_rem = 18'(s_rem - RW'(DAYS_400));
    end else begin
      fix_quo = s_qest;
      fix_rem = 18'(s_rem);
    end
  end

  // centuries within the 400-year cycle
  always_comb begin
    r18 = t_rem;
    if (r18 >= 18'(4 * DAYS_100)) begin
      c100 = 3'd4;
    end else if (r18 >= 18'(3 * DAYS_100)) begin
      c100 = 3'd3;
    end else if (r18 >= 18'(2 * DAYS_100)) begin
      c100 = 3'd2;
    end else if (r18 >= 18'(DAYS_100)) begin
      c100 = 3'd1;
    end else begin
      c100 = 3'd0;
    end
    sub100 = 18'(c100) * 18'(DAYS_100);
  end

  // 4-year cycles within the century, restoring division over five bits
  always_comb begin
    r4y = c_rem;
    c4  = '0;
    for (int j = 4; j >= 0; j--) begin
      if (r4y >= (16'(DAYS_4) << j)) begin
        r4y   = r4y - (16'(DAYS_4) << j);
        c4[j] = 1'b1;
      end
    end
  end

  // single years within the 4-year cycle
  always_comb begin
    if (d_rem >= 11'(4 * DAYS_1)) begin
      c1 = 3'd4;
    end else if (d_rem >= 11'(3 * DAYS_1)) begin
      c1 = 3'd3;
    end else if (d_rem >= 11'(2 * DAYS_1)) begin
      c1 = 3'd2;
    end else if (d_rem >= 11'(DAYS_1)) begin
      c1 = 3'd1;
    end else begin
      c1 = 3'd0;
    end
    sub1 = 9'(11'(c1) * 11'(DAYS_1));
  end

  // month search over the start-of-month table
  always_comb begin
    mon = '0;
    for (int k = 1; k < 12; k++) begin
      if (e_rem >= month_start(4'(k), e_leap)) mon = 4'(k);
    end
    mstart = month_start(mon, e_leap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_ord  <= q_data;

      p_qest <= est_prod[PW-1:QW];
      p_lo   <= r_ord[RW-1:0];

      s_qest <= p_qest;
      s_rem  <= p_lo - est_back;

      t_quo  <= fix_quo;
      t_rem  <= fix_rem;

      c_quo  <= t_quo;
      c_c100 <= c100;
      c_rem  <= 16'(r18 - sub100);

      d_base <= YW'(c_quo) * YW'(400) + YW'(c_c100) * YW'(100);
      d_c100 <= c_c100;
      d_c4   <= c4;
      d_rem  <= r4y[10:0];

      e_ry   <= d_base + (YW'(d_c4) << 2) + YW'(c1) + YW'(1);
      e_rem  <= 9'(d_rem) - sub1;
      e_leap <= (c1 == 3'd3) && ((d_c4 != 5'd24) || (d_c100 == 3'd3));
      e_last <= (c1 == 3'd4) || (d_c100 == 3'd4);

      if (e_last) begin
        // last day of a leap cycle: December 31 of the year before
        result_day   <= DAY_LAST_DEC;
        result_month <= MONTH_DEC;
        result_year  <= YEAR_OUT_W'(e_ry - YW'(1));
      end else begin
        result_day   <= DAY_W'(e_rem - mstart + 9'd1);
        result_month <= mon + 4'd1;
        result_year  <= YEAR_OUT_W'(e_ry);
      end
    end
  end

endmodule

// ----- hw/rtl/gregorian_date_add_days_top.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top: Gregorian date plus a day count
// Adds days_to_add to a proleptic Gregorian date and returns the new date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries start_day, start_month,
//   start_year and days_to_add; one transfer per edge with both high.
//   Output channel (out_valid/out_ready) carries result_day, result_month
//   and result_year, one result transfer for every input transfer, in order.
//   Throughput: one date per cycle, sustained, while out_ready stays high.
//   Path: from input transfer to out_valid at any OFFSET_BITS an item passes
//   the second front stage, the queue write and eight back stages (operand,
//   reciprocal estimate of the 400-year cycles, remainder, correction,
//   centuries, 4-year cycles, single years, month search with output).
//   The front (ordinal computation, 2 stages) feeds a 4-entry queue; the
//   back (division, cycle steps, month search, output register) drains it.
//   Stall: when out_ready is low the back holds; the queue fills, and then
//   the front holds and in_ready drops. in_ready depends only on state and
//   rst, not combinationally on out_ready.
//   Reset (rst, synchronous): empties the pipelines and the queue; in_ready
//   stays low during reset and the block accepts items in the cycle after
//   reset is released.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top import gdad_pkg::*; #(
  parameter int OFFSET_BITS = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DAY_W-1:0]       start_day,
  input  logic [MONTH_W-1:0]     start_month,
  input  logic [YEAR_IN_W-1:0]   start_year,
  input  logic [OFFSET_BITS-1:0] days_to_add,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DAY_W-1:0]       result_day,
  output logic [MONTH_W-1:0]     result_month,
  output logic [YEAR_OUT_W-1:0]  result_year
);

  // ordinal width: start ordinal (24 bits) or offset, plus a carry
  localparam int ORD_W = ((OFFSET_BITS > BASE_W) ? OFFSET_BITS : BASE_W) + 1;

  logic             push, q_full, q_empty, pop;
  logic [ORD_W-1:0] push_ord, q_data;

  // front: date to ordinal, offset added
  gdad_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .push        (push),
    .push_ord    (push_ord),
    .q_full      (q_full)
  );

  // queue: lets front and back stall on their own
  gdad_queue #(.WIDTH(ORD_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_ord),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: ordinal to date, output register
  gdad_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year)
  );

endmodule

// ----- test/tb_gregorian_date_add_days_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days_top: self-checking bench for the date adder
// Sends start dates with day offsets through the valid/ready input channel.
// For every input transfer it computes the expected calendar date and checks
// each output transfer against the oldest one still waiting. Both channels
// idle at random. The order of tests is: corner dates, a drain pause,
// random valid dates, a full-rate burst, then raw field values, in range or not.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days_top import gdad_pkg::*;;

  localparam int OFFSET_BITS    = 30;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [YEAR_OUT_W-1:0] year;
  } date_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [DAY_W-1:0]       start_day = '0;
  logic [MONTH_W-1:0]     start_month = '0;
  logic [YEAR_IN_W-1:0]   start_year = '0;
  logic [OFFSET_BITS-1:0] days_to_add = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DAY_W-1:0]       result_day;
  logic [MONTH_W-1:0]     result_month;
  logic [YEAR_OUT_W-1:0]  result_year;

  // Dates whose results have not come out yet, oldest first.
  date_t pending_dates[$];
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  int    sink_wait = 0;
  bit    src_idle_en = 1'b1;
  bit    sink_stall_en = 1'b1;

  gregorian_date_add_days_top #(
    .OFFSET_BITS (OFFSET_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .days_to_add  (days_to_add),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar arithmetic of the expected results
  // --------------------------------------------------------------------------
  function automatic bit is_leap(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Length of month index k (0 = January).
  function automatic int unsigned days_in_month(int unsigned k, bit leap);
    case (k)
      1:           return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic date_t predict_date(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                         logic [YEAR_IN_W-1:0] y,
                                         logic [OFFSET_BITS-1:0] add);
    longint unsigned prior, ord, q400, q100, q4, q1, yr;
    int unsigned     mon, len, k;
    bit              leap_now;
    date_t           r;
    // Fold the start date into a day count from 0001-01-01, biased by one so
    // that a zero day cannot go negative before the clamp.
    prior = (y >= 1) ? longint'(y) - 1 : 0;
    ord = prior * 365 + prior / 4 - prior / 100 + prior / 400;
    mon = (m == 0) ? 32'(MONTH_JAN) : ((m > MONTH_DEC) ? 32'(MONTH_DEC) : 32'(m));
    for (k = 0; k + 1 < mon; k++) ord += days_in_month(k, 1'b0);
    if (mon > MONTH_FEB && is_leap(y)) ord += 1;
    ord += d;
    ord = (ord >= 1) ? ord - 1 : 0;
    ord += add;
    // Peel off 400-, 100-, 4- and 1-year cycles.
    q400 = ord / DAYS_400; ord = ord % DAYS_400;
    q100 = ord / DAYS_100; ord = ord % DAYS_100;
    q4   = ord / DAYS_4;   ord = ord % DAYS_4;
    q1   = ord / DAYS_1;   ord = ord % DAYS_1;
    yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
    if (q1 == 4 || q100 == 4) begin
      // Day 366 of a leap year that closes a 4- or 400-year cycle.
      r.day   = DAY_LAST_DEC;
      r.month = MONTH_DEC;
      r.year  = YEAR_OUT_W'(yr - 1);
      return r;
    end
    leap_now = (q1 == 3) && (q4 != 24 || q100 == 3);
    mon = 0;
    for (k = 0; k < 12; k++) begin
      len = days_in_month(k, leap_now);
      if (ord < len) begin
        mon = k;
        break;
      end
      ord -= len;
    end
    r.day   = DAY_W'(ord + 1);
    r.month = MONTH_W'(mon + 1);
    r.year  = YEAR_OUT_W'(yr);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly no gap, some short ones, a few long stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offset of random bit length, so small and huge offsets both show up.
  function automatic logic [OFFSET_BITS-1:0] rand_offset();
    int unsigned w;
    logic [63:0] raw;
    w = $urandom_range(0, OFFSET_BITS);
    raw = {$urandom, $urandom};
    if (w == 0) return '0;
    return OFFSET_BITS'(raw & ((64'd1 << w) - 64'd1));
  endfunction

  // --------------------------------------------------------------------------
  // Input side: send one date, holding valid and payload until the transfer
  // --------------------------------------------------------------------------
  // Entered and left at a rising edge. Valid is lowered only when a gap
  // follows, so it never gets two updates in one step.
  task automatic send_date(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                           logic [YEAR_IN_W-1:0] y, logic [OFFSET_BITS-1:0] add);
    int    gap;
    date_t want;
    gap = src_idle_en ? pick_gap() : 0;
    want = predict_date(d, m, y, add);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    days_to_add <= add;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(want);
  endtask

  // Hold the sender until every result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_dates.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls and result checking
  // --------------------------------------------------------------------------
  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_dates.size() == 0) begin
          $error("result %0d-%0d-%0d with no date pending",
                 result_year, result_month, result_day);
          mismatch_count++;
        end else begin
          date_t want;
          want = pending_dates.pop_front();
          compare_field("result_day", want.day, result_day);
          compare_field("result_month", want.month, result_month);
          compare_field("result_year", want.year, result_year);
        end
      end
      if (sink_wait != 0) begin
        out_ready <= 1'b0;
        sink_wait <= sink_wait - 1;
      end else begin
        out_ready <= 1'b1;
        if (sink_stall_en && $urandom_range(0, 3) == 0) sink_wait <= pick_gap();
      end
    end
  end

  // Abort when no transfer happens for too long on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner dates: field extremes, cycle ends, leap rules, and the folded
  // out-of-range day, month and year values.
  task automatic test_corner_dates();
    send_date(5'd1, 4'd1, 14'd1, '0);
    send_date(5'd31, 4'd12, 14'd9999, '1);
    send_date(5'd31, 4'd15, 14'd16383, '1);      // every input bit high
    send_date(5'd0, 4'd0, 14'd0, '0);            // negative ordinal clamps
    send_date(5'd0, 4'd1, 14'd1, '0);
    send_date(5'd31, 4'd2, 14'd2001, '0);        // day past month length
    send_date(5'd0, 4'd3, 14'd2000, '0);         // day zero
    send_date(5'd15, 4'd0, 14'd2020, 30'd10);    // month zero
    send_date(5'd10, 4'd13, 14'd2021, '0);       // month above twelve
    send_date(5'd20, 4'd15, 14'd1999, 30'd100);
    send_date(5'd1, 4'd3, 14'd0, '0);            // year zero is leap
    send_date(5'd29, 4'd2, 14'd0, 30'd1);
    send_date(5'd29, 4'd2, 14'd2000, '0);
    send_date(5'd29, 4'd2, 14'd1900, '0);        // century, not leap
    send_date(5'd28, 4'd2, 14'd2100, 30'd1);
    send_date(5'd31, 4'd12, 14'd2000, '0);       // last day of 400-year cycle
    send_date(5'd31, 4'd12, 14'd1996, '0);       // last day of 4-year cycle
    send_date(5'd31, 4'd12, 14'd1999, 30'd1);
    send_date(5'd1, 4'd1, 14'd1, 30'd146097);
    send_date(5'd1, 4'd1, 14'd1, 30'd146096);
    send_date(5'd1, 4'd1, 14'd1, 30'd1460);
    send_date(5'd1, 4'd1, 14'd1, 30'd365);
    send_date(5'd30, 4'd6, 14'd2024, 30'd36524);
  endtask

  task automatic test_drain_pause();
    send_date(5'd14, 4'd7, 14'd1789, rand_offset());
    wait_drained();
    send_date(5'd4, 4'd10, 14'd1582, rand_offset());
  endtask

  task automatic test_random_dates(int count);
    logic [MONTH_W-1:0]   m;
    logic [YEAR_IN_W-1:0] y;
    for (int i = 0; i < count; i++) begin
      y = YEAR_IN_W'($urandom_range(1, 9999));
      m = MONTH_W'($urandom_range(1, 12));
      send_date(DAY_W'($urandom_range(1, days_in_month(32'(m) - 1, is_leap(y)))),
                m, y, rand_offset());
    end
  endtask

  // Back-to-back transfers with both sides always ready.
  task automatic test_full_rate(int count);
    src_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    test_random_dates(count);
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // Any field value the ports allow, small years favored for the clamp.
  task automatic test_raw_fields(int count);
    logic [YEAR_IN_W-1:0] y;
    for (int i = 0; i < count; i++) begin
      y = ($urandom_range(0, 4) == 0) ? YEAR_IN_W'($urandom_range(0, 2))
                                      : YEAR_IN_W'($urandom);
      send_date(DAY_W'($urandom), MONTH_W'($urandom), y,
                ($urandom_range(0, 3) == 0) ? '0 : rand_offset());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_corner_dates();
    test_drain_pause();
    test_random_dates(300);
    test_full_rate(80);
    test_raw_fields(120);
    in_valid <= 1'b0;
    // Let every result come out, then watch for strays.
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
